// ----- rtl/vcpt_pkg.sv -----
`timescale 1ns / 1ps
package vcpt_pkg;

    localparam int TIME_BITS = 64;
    typedef logic [TIME_BITS-1:0] time_t;

    // largest time value, held in 64 bits
    localparam logic [63:0] TMASK = {64{1'b1}} >> (64 - TIME_BITS);

    // item operation codes
    localparam logic [1:0] OP_PKT = 2'd0;
    localparam logic [1:0] OP_BW  = 2'd1;
    localparam logic [1:0] OP_CLR = 2'd2;

    // result status codes
    localparam logic [1:0] ST_TAGGED = 2'd0;
    localparam logic [1:0] ST_PASS   = 2'd1;
    localparam logic [1:0] ST_DROP   = 2'd2;
    localparam logic [1:0] ST_CTRL   = 2'd3;

    // configuration register indexes
    localparam int ADDR_BITS = 4;
    localparam logic [ADDR_BITS-3:0] REG_RATE   = 2'd0;
    localparam logic [ADDR_BITS-3:0] REG_MAX_BW = 2'd1;
    localparam logic [ADDR_BITS-3:0] REG_ACTIVE = 2'd2;

    localparam logic [29:0] NS_PER_SEC = 30'd1000000000;
    localparam int LEN_NS_BITS = 46;

    localparam int DIV_STEPS = 64;
    localparam int CNT_BITS  = $clog2(DIV_STEPS + 1);

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] length;
        logic [63:0] now_ns;
        logic [31:0] new_bw;
    } req_t;

    typedef struct packed {
        logic [63:0] tag;
        logic [1:0]  status;
    } rsp_t;

    typedef struct packed {
        logic [31:0] rate;
        logic [31:0] max_bw;
        logic        active;
    } cfg_t;

    typedef struct packed {
        logic       capture;
        logic       prep;
        logic       mul_lo;
        logic       mul_hi;
        logic       sum;
        logic       div_start;
        logic       adv;
        logic       do_tag;
        logic       clear;
        logic       load;
        logic [1:0] code;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       active;
        logic       rate_zero;
        logic       div_busy;
        logic       out_free;
    } sts_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_MUL_LO,
        S_MUL_HI,
        S_SUM,
        S_DIV_START,
        S_DIV_WAIT,
        S_ADV,
        S_TAG,
        S_RESULT
    } state_t;

    // a + b, saturated at the largest time value
    function automatic time_t sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s > {1'b0, TMASK})
            return TMASK[TIME_BITS-1:0];
        return s[TIME_BITS-1:0];
    endfunction

endpackage

// ----- rtl/vcpt_div.sv -----
`timescale 1ns / 1ps
module vcpt_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] num_hi,
    input  logic [63:0] num_lo,
    input  logic [31:0] den,
    output logic [63:0] quo,
    output logic        ovf,
    output logic        busy
);
    import vcpt_pkg::*;

    logic [31:0]         rem_reg, rem_next;
    logic [63:0]         quo_reg, quo_next;
    logic [31:0]         den_reg, den_next;
    logic                ovf_reg, ovf_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic [32:0]         trial;
    logic [32:0]         diff;
    logic                ge;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[63]};
        diff      = trial - {1'b0, den_reg};
        ge        = trial >= {1'b0, den_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        ovf_next  = ovf_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            // quotient would not fit in 64 bits
            ovf_next  = num_hi >= den;
            rem_next  = num_hi;
            quo_next  = num_lo;
            den_next  = den;
            cnt_next  = CNT_BITS'(DIV_STEPS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // dividend bits shift out the top, quotient bits in at the bottom
            rem_next = ge ? diff[31:0] : trial[31:0];
            quo_next = {quo_reg[62:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        ovf_reg <= ovf_next;
    end

    assign quo  = quo_reg;
    assign ovf  = ovf_reg;
    assign busy = busy_reg;

endmodule

// ----- rtl/vcpt_datapath.sv -----
`timescale 1ns / 1ps
module vcpt_datapath (
    input  logic          clk,
    input  logic          rst_n,
    input  vcpt_pkg::cmd_t cmd,
    output vcpt_pkg::sts_t sts,
    input  vcpt_pkg::cfg_t cfg,
    input  vcpt_pkg::req_t req,
    input  logic          rsp_stall,
    output logic          rsp_valid,
    output vcpt_pkg::rsp_t rsp
);
    import vcpt_pkg::*;

    // item
    logic [1:0]  op_reg, op_next;
    logic [15:0] length_reg, length_next;
    time_t       now_reg, now_next;
    logic [31:0] new_bw_reg, new_bw_next;

    // clock state
    time_t       last_tag_reg, last_tag_next;
    time_t       vt_reg, vt_next;
    time_t       last_real_reg, last_real_next;
    logic [31:0] cur_bw_reg, cur_bw_next;

    // work registers
    time_t                  elapsed_reg, elapsed_next;
    logic [31:0]            scale_reg, scale_next;
    logic [63:0]            plo_reg, plo_next;
    logic [63:0]            phi_reg, phi_next;
    logic [95:0]            prod_reg, prod_next;
    logic [LEN_NS_BITS-1:0] dlen_reg, dlen_next;

    rsp_t rsp_reg, rsp_next;
    logic rsp_valid_reg, rsp_valid_next;

    logic [63:0] elapsed64;
    logic [63:0] adv_q;
    logic        adv_ovf;
    logic        adv_busy;
    logic [63:0] len_q;
    logic        len_ovf;
    logic        len_busy;
    logic [63:0] adv_sat;
    time_t       base;

    vcpt_div u_adv_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.div_start),
        .num_hi (prod_reg[95:64]),
        .num_lo (prod_reg[63:0]),
        .den    (cur_bw_reg),
        .quo    (adv_q),
        .ovf    (adv_ovf),
        .busy   (adv_busy)
    );

    vcpt_div u_len_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.div_start),
        .num_hi (32'd0),
        .num_lo (64'(dlen_reg)),
        .den    (cfg.rate),
        .quo    (len_q),
        .ovf    (len_ovf),
        .busy   (len_busy)
    );

    always_comb
    begin
        elapsed64 = 64'(elapsed_reg);
        adv_sat   = (adv_ovf || adv_q > TMASK) ? TMASK : adv_q;
        base      = (last_tag_reg > vt_reg) ? last_tag_reg : vt_reg;

        op_next        = op_reg;
        length_next    = length_reg;
        now_next       = now_reg;
        new_bw_next    = new_bw_reg;
        last_tag_next  = last_tag_reg;
        vt_next        = vt_reg;
        last_real_next = last_real_reg;
        cur_bw_next    = cur_bw_reg;
        elapsed_next   = elapsed_reg;
        scale_next     = scale_reg;
        plo_next       = plo_reg;
        phi_next       = phi_reg;
        prod_next      = prod_reg;
        dlen_next      = dlen_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;

        if (rsp_valid_reg && !rsp_stall)
            rsp_valid_next = 1'b0;

        if (cmd.capture)
        begin
            op_next     = req.op;
            length_next = req.length;
            now_next    = req.now_ns[TIME_BITS-1:0];
            new_bw_next = req.new_bw;
        end

        if (cmd.prep)
        begin
            // time running backwards counts as no elapsed time
            elapsed_next = (now_reg > last_real_reg) ? now_reg - last_real_reg : '0;
            scale_next   = (cfg.max_bw != 32'd0) ? cfg.max_bw : cfg.rate;
        end

        if (cmd.mul_lo)
        begin
            plo_next  = elapsed64[31:0] * scale_reg;
            dlen_next = length_reg * NS_PER_SEC;
        end

        if (cmd.mul_hi)
            phi_next = elapsed64[63:32] * scale_reg;

        if (cmd.sum)
            prod_next = {32'd0, plo_reg} + {phi_reg, 32'd0};

        if (cmd.adv)
        begin
            // zero bandwidth: virtual time follows real time
            if (cur_bw_reg == 32'd0)
                vt_next = now_reg;
            else
                vt_next = sat_add(64'(vt_reg), adv_sat);
            last_real_next = now_reg;
            if (op_reg == OP_BW)
                cur_bw_next = new_bw_reg;
        end

        if (cmd.do_tag)
            last_tag_next = sat_add(64'(base), len_q);

        if (cmd.clear)
        begin
            last_tag_next  = '0;
            vt_next        = '0;
            last_real_next = '0;
        end

        if (cmd.load)
        begin
            rsp_next.status = cmd.code;
            rsp_next.tag    = (cmd.code == ST_TAGGED) ? 64'(last_tag_reg) : 64'd0;
            rsp_valid_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_tag_reg  <= '0;
            vt_reg        <= '0;
            last_real_reg <= '0;
            cur_bw_reg    <= 32'd1;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            last_tag_reg  <= last_tag_next;
            vt_reg        <= vt_next;
            last_real_reg <= last_real_next;
            cur_bw_reg    <= cur_bw_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        length_reg  <= length_next;
        now_reg     <= now_next;
        new_bw_reg  <= new_bw_next;
        elapsed_reg <= elapsed_next;
        scale_reg   <= scale_next;
        plo_reg     <= plo_next;
        phi_reg     <= phi_next;
        prod_reg    <= prod_next;
        dlen_reg    <= dlen_next;
        rsp_reg     <= rsp_next;
    end

    always_comb
    begin
        sts.op        = op_reg;
        sts.active    = cfg.active;
        sts.rate_zero = cfg.rate == 32'd0;
        sts.div_busy  = adv_busy || len_busy;
        sts.out_free  = !rsp_valid_reg || !rsp_stall;
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

    // with a nonzero rate the length quotient is below 2^46, so its overflow flag stays low
    logic unused_len_ovf;
    assign unused_len_ovf = len_ovf;

endmodule

// ----- rtl/vcpt_ctrl.sv -----
`timescale 1ns / 1ps
module vcpt_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  vcpt_pkg::sts_t sts,
    output vcpt_pkg::cmd_t cmd
);
    import vcpt_pkg::*;

    state_t     state_reg, state_next;
    logic [1:0] code_reg, code_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            code_reg  <= ST_CTRL;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        code_next  = code_reg;
        cmd        = '0;
        cmd.code   = code_reg;
        req_stall  = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                req_stall   = 1'b0;
                cmd.capture = req_valid;
                if (req_valid)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.prep = 1'b1;
                unique case (sts.op)
                    OP_PKT:
                    begin
                        if (!sts.active)
                        begin
                            code_next  = ST_PASS;
                            state_next = S_RESULT;
                        end
                        else if (sts.rate_zero)
                        begin
                            code_next  = ST_DROP;
                            state_next = S_RESULT;
                        end
                        else
                        begin
                            code_next  = ST_TAGGED;
                            state_next = S_MUL_LO;
                        end
                    end
                    OP_BW:
                    begin
                        code_next  = ST_CTRL;
                        state_next = S_MUL_LO;
                    end
                    OP_CLR:
                    begin
                        cmd.clear  = 1'b1;
                        code_next  = ST_CTRL;
                        state_next = S_RESULT;
                    end
                    default:
                    begin
                        code_next  = ST_CTRL;
                        state_next = S_RESULT;
                    end
                endcase
            end
            S_MUL_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = S_MUL_HI;
            end
            S_MUL_HI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = S_DIV_START;
            end
            S_DIV_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (!sts.div_busy)
                    state_next = S_ADV;
            end
            S_ADV:
            begin
                cmd.adv    = 1'b1;
                state_next = (code_reg == ST_TAGGED) ? S_TAG : S_RESULT;
            end
            S_TAG:
            begin
                cmd.do_tag = 1'b1;
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                // wait here while the output register still holds an untaken item
                if (sts.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/virtual_clock_packet_tagger_core.sv -----
// virtual clock packet tagger
// requests come in on req/req_valid/req_stall: op 0 tags a packet of the given
// length at real time now_ns, op 1 advances virtual time and loads a new current
// bandwidth, op 2 clears last tag, virtual time and last real time.
// every item gives exactly one result on rsp/rsp_valid/rsp_stall: the tag and a
// status (tagged, passed while inactive, dropped for zero rate, control done).
// rate, max_bw and active are to be written over the apb port only while no item
// is in work; the block does not enforce this. packets and bandwidth changes run
// through two 64-step restoring dividers that work side by side (scaled elapsed
// time by current bandwidth, length in ns by rate): a tagged packet goes through
// check, multiplies, sum, divide, advance and tag before its result is loaded; a
// bandwidth change skips the tag; cleared, passed, dropped and unknown items go
// from check straight to the result. one item is in work at a time: the next is
// taken once the block is idle. the output register frees the input side: the
// next item is accepted while a result waits, and a stalled receiver only holds
// the block once its next result is ready. reset clears all times, sets current
// bandwidth, rate, max_bw and active to one, and leaves the output empty.
`timescale 1ns / 1ps
module virtual_clock_packet_tagger_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  vcpt_pkg::req_t                 req,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output vcpt_pkg::rsp_t                 rsp,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [vcpt_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import vcpt_pkg::*;

    logic [31:0] rate_reg, rate_next;
    logic [31:0] max_bw_reg, max_bw_next;
    logic        active_reg, active_next;
    logic [ADDR_BITS-3:0] reg_idx;
    logic        wr_en;
    cfg_t        cfg;
    cmd_t        cmd;
    sts_t        sts;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_BITS-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb
    begin
        rate_next   = rate_reg;
        max_bw_next = max_bw_reg;
        active_next = active_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_RATE:   rate_next   = pwdata;
                REG_MAX_BW: max_bw_next = pwdata;
                REG_ACTIVE: active_next = pwdata[0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_RATE:   prdata = rate_reg;
            REG_MAX_BW: prdata = max_bw_reg;
            REG_ACTIVE: prdata = {31'd0, active_reg};
            default:    prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg   <= 32'd1;
            max_bw_reg <= 32'd1;
            active_reg <= 1'b1;
        end
        else
        begin
            rate_reg   <= rate_next;
            max_bw_reg <= max_bw_next;
            active_reg <= active_next;
        end
    end

    always_comb
    begin
        cfg.rate   = rate_reg;
        cfg.max_bw = max_bw_reg;
        cfg.active = active_reg;
    end

    vcpt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    vcpt_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .cfg       (cfg),
        .req       (req),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule

// ----- tb/vcpt_tag_checker.sv -----
`timescale 1ns / 1ps
module vcpt_tag_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    input  logic                           req_stall,
    input  vcpt_pkg::req_t                 req,
    input  logic                           rsp_valid,
    input  logic                           rsp_stall,
    input  vcpt_pkg::rsp_t                 rsp,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic                           pready,
    input  logic [vcpt_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output int                             errors,
    output int                             outstanding
);
    import vcpt_pkg::*;

    // register copies, kept up to date from the apb writes
    logic [31:0] cfg_rate;
    logic [31:0] cfg_max_bw;
    logic        cfg_active;

    // scheduler state
    logic [63:0] fin_tag;
    logic [63:0] vtime;
    logic [63:0] real_seen;
    logic [31:0] cur_bw;

    rsp_t expected_q[$];
    rsp_t want;
    int   fail_count;

    assign errors = fail_count;

    function automatic logic [63:0] clamp_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s[64] || s[63:0] > TMASK) ? TMASK : s[63:0];
    endfunction

    // span * num / den with the quotient clamped to the time range
    function automatic logic [63:0] scaled_span(input logic [63:0] span, input logic [31:0] num,
                                                input logic [31:0] den);
        logic [95:0] q;
        q = ({32'b0, span} * {64'b0, num}) / {64'b0, den};
        return (q > {32'b0, TMASK}) ? TMASK : q[63:0];
    endfunction

    function automatic void advance_vtime(input logic [63:0] now);
        logic [31:0] scale;
        logic [63:0] span;
        if (cur_bw == '0)
        begin
            vtime = now;
        end
        else
        begin
            scale = (cfg_max_bw != '0) ? cfg_max_bw : cfg_rate;
            span  = (now > real_seen) ? now - real_seen : '0;
            vtime = clamp_add(vtime, scaled_span(span, scale, cur_bw));
        end
        real_seen = now;
    endfunction

    function automatic rsp_t tag_item(input req_t item);
        logic [63:0] now;
        logic [63:0] base;
        logic [63:0] span_ns;
        rsp_t        res;
        now        = item.now_ns & TMASK;
        res.tag    = '0;
        res.status = ST_CTRL;
        case (item.op)
            OP_PKT:
            begin
                if (!cfg_active)
                begin
                    res.status = ST_PASS;
                end
                else if (cfg_rate == '0)
                begin
                    res.status = ST_DROP;
                end
                else
                begin
                    span_ns = ({48'b0, item.length} * {34'b0, NS_PER_SEC}) / {32'b0, cfg_rate};
                    advance_vtime(now);
                    base       = (fin_tag > vtime) ? fin_tag : vtime;
                    fin_tag    = clamp_add(base, span_ns);
                    res.tag    = fin_tag;
                    res.status = ST_TAGGED;
                end
            end
            OP_BW:
            begin
                advance_vtime(now);
                cur_bw = item.new_bw;
            end
            OP_CLR:
            begin
                fin_tag   = '0;
                vtime     = '0;
                real_seen = '0;
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_rate   = 32'd1;
            cfg_max_bw = 32'd1;
            cfg_active = 1'b1;
            fin_tag    = '0;
            vtime      = '0;
            real_seen  = '0;
            cur_bw     = 32'd1;
            fail_count = 0;
            expected_q.delete();
            outstanding <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[ADDR_BITS-1:2])
                    REG_RATE:   cfg_rate   = pwdata;
                    REG_MAX_BW: cfg_max_bw = pwdata;
                    REG_ACTIVE: cfg_active = pwdata[0];
                    default:
                    begin
                    end
                endcase
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result with nothing pending: tag %h status %0d",
                             $time, rsp.tag, rsp.status);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (rsp.tag !== want.tag || rsp.status !== want.status)
                    begin
                        fail_count++;
                        $display("%0t: mismatch: expected tag %h status %0d, got tag %h status %0d",
                                 $time, want.tag, want.status, rsp.tag, rsp.status);
                    end
                end
            end
            if (req_valid && !req_stall)
                expected_q.push_back(tag_item(req));
            outstanding <= expected_q.size();
        end
    end

endmodule

// ----- tb/virtual_clock_packet_tagger_core_test.sv -----
`timescale 1ns / 1ps
module virtual_clock_packet_tagger_core_test;
    import vcpt_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         CYCLE_LIMIT = 1_000_000;
    localparam int         SETTLE      = 80;
    localparam int         PHASES      = 8;
    localparam int         PHASE_ITEMS = 150;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 req_valid = 1'b0;
    logic                 req_stall;
    req_t                 req       = '0;
    logic                 rsp_valid;
    logic                 rsp_stall = 1'b0;
    rsp_t                 rsp;
    logic                 psel      = 1'b0;
    logic                 penable   = 1'b0;
    logic                 pwrite    = 1'b0;
    logic [ADDR_BITS-1:0] paddr     = '0;
    logic [31:0]          pwdata    = '0;
    logic [31:0]          prdata;
    logic                 pready;

    int          errors;
    int          outstanding;
    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    int          cycles        = 0;
    logic [63:0] now_cursor    = '0;

    virtual_clock_packet_tagger_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    vcpt_tag_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .errors      (errors),
        .outstanding (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        rsp_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("virtual_clock_packet_tagger_core_test: FAIL");
            $finish;
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [15:0] len,
                             input logic [63:0] now, input logic [31:0] bw);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req       <= {op, len, now, bw};
        req_valid <= 1'b1;
        do @(posedge clk); while (req_stall);
    endtask

    // stop sending and wait until every item has come back
    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // psel stays high across back-to-back writes; configure drops it once at the end
    task automatic write_reg(input logic [ADDR_BITS-3:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
    endtask

    task automatic configure(input logic [31:0] rate_val, input logic [31:0] max_bw_val,
                             input logic active_val);
        drain();
        write_reg(REG_RATE, rate_val);
        write_reg(REG_MAX_BW, max_bw_val);
        write_reg(REG_ACTIVE, {31'b0, active_val});
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic random_item();
        int          roll;
        logic [1:0]  op;
        logic [15:0] len;
        logic [63:0] now;
        logic [31:0] bw;
        roll = $urandom_range(99);
        if (roll < 62)
            op = OP_PKT;
        else if (roll < 84)
            op = OP_BW;
        else if (roll < 90)
            op = OP_CLR;
        else if (roll < 94)
            op = OP_UNUSED;
        else
            op = 2'($urandom_range(3));

        roll = $urandom_range(99);
        if (roll < 10)
            len = '0;
        else if (roll < 20)
            len = 16'hffff;
        else
            len = 16'($urandom_range(65535));

        // mostly forward-moving time, some steps back and some wild values
        roll = $urandom_range(99);
        if (roll < 80)
        begin
            now_cursor = now_cursor + 64'($urandom_range(20000));
            now        = now_cursor;
        end
        else if (roll < 90)
        begin
            now = now_cursor - 64'($urandom_range(5000));
        end
        else
        begin
            now = {$urandom, $urandom};
        end

        roll = $urandom_range(99);
        if (roll < 10)
            bw = '0;
        else if (roll < 20)
            bw = 32'd1;
        else if (roll < 30)
            bw = 32'hffff_ffff;
        else if (roll < 60)
            bw = 32'($urandom_range(1, 1000));
        else
            bw = $urandom;

        send_item(op, len, now, bw);
        if (op == OP_CLR)
            now_cursor = '0;
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: rate, max_bw, current bandwidth all one
        send_item(OP_PKT, 16'd0, 64'd0, 32'd0);
        send_item(OP_PKT, 16'hffff, 64'd100, 32'd0);
        send_item(OP_PKT, 16'd1, 64'd50, 32'd0);           // time going backwards
        send_item(OP_BW, 16'd0, 64'd200, 32'd0);           // current bandwidth zero
        send_item(OP_PKT, 16'd1500, 64'd1000, 32'hffff_ffff);
        send_item(OP_BW, 16'd0, 64'd2000, 32'hffff_ffff);
        send_item(OP_PKT, 16'd64, 64'hffff_ffff_ffff_ffff, 32'd0);
        send_item(OP_BW, 16'd0, 64'hffff_ffff_ffff_ffff, 32'd1);
        send_item(OP_CLR, 16'd0, 64'd0, 32'd0);
        send_item(OP_UNUSED, 16'hffff, 64'hffff_ffff_ffff_ffff, 32'hffff_ffff);
        send_item(OP_PKT, 16'd1, 64'hffff_ffff_ffff_ffff, 32'd0);  // virtual time reaches its top, the tag saturates
        send_item(OP_PKT, 16'hffff, 64'hffff_ffff_ffff_ffff, 32'd0);
        send_item(OP_CLR, 16'd0, 64'd0, 32'd0);

        configure(32'hffff_ffff, 32'hffff_ffff, 1'b1);
        send_item(OP_BW, 16'd0, 64'd0, 32'd1);
        send_item(OP_PKT, 16'hffff, 64'h0000_0002_0000_0000, 32'd0);  // scaled advance overflows
        send_item(OP_CLR, 16'd0, 64'd0, 32'd0);

        // zero rate drops, zero max_bw falls back to a zero rate
        configure(32'd0, 32'd0, 1'b1);
        send_item(OP_PKT, 16'd100, 64'd100, 32'd0);
        send_item(OP_BW, 16'd0, 64'd500, 32'd7);
        send_item(OP_PKT, 16'hffff, 64'd600, 32'd0);

        configure(32'd1000, 32'd0, 1'b1);
        send_item(OP_BW, 16'd0, 64'd1000, 32'd3);
        send_item(OP_PKT, 16'd100, 64'd4000, 32'd0);

        configure(32'd5, 32'd3, 1'b0);
        send_item(OP_PKT, 16'd100, 64'd4500, 32'd0);
        send_item(OP_BW, 16'd0, 64'd5000, 32'd2);
        send_item(OP_PKT, 16'hffff, 64'd6000, 32'd0);

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: configure(32'hffff_ffff, 32'hffff_ffff, 1'b1);
                1: configure(32'd1, 32'd0, 1'b1);
                2: configure($urandom, $urandom, 1'b1);
                3: configure(32'($urandom_range(1, 1_000_000)), 32'd1, 1'b1);
                4: configure(32'd0, $urandom, 1'b1);
                5: configure($urandom, $urandom, 1'b0);
                6: configure(32'($urandom_range(1, 100000)), 32'($urandom_range(1, 1000)), 1'b1);
                default: configure($urandom, 32'd0, 1'b1);
            endcase
            case (p % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 85;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 85;
                end
                default:
                begin
                    send_idle_pct = 19;
                    stall_pct     = 19;
                end
            endcase
            now_cursor = '0;
            send_item(OP_CLR, 16'd0, 64'd0, 32'd0);
            for (int i = 0; i < PHASE_ITEMS; i++)
                random_item();
        end

        drain();
        repeat (SETTLE) @(posedge clk);
        if (errors == 0)
            $display("virtual_clock_packet_tagger_core_test: PASS");
        else
            $display("virtual_clock_packet_tagger_core_test: FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/vcpt_pkg.sv
rtl/vcpt_div.sv
rtl/vcpt_datapath.sv
rtl/vcpt_ctrl.sv
rtl/virtual_clock_packet_tagger_core.sv
tb/vcpt_tag_checker.sv
tb/virtual_clock_packet_tagger_core_test.sv
